// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands for the slot allocator
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define CSA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define CSA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/csa_pkg.sv =====
// ---------------------------------------------------------------------------
// csa_pkg
// shared types, codes and helpers of the contiguous slot allocator
// ---------------------------------------------------------------------------
`default_nettype none

package csa_pkg;

	localparam int NumSlots = 16;
	localparam int CntW     = 5;
	localparam int SlotW    = 4;

	typedef logic [NumSlots-1:0] slot_vec_t;

	typedef enum logic {
		ACT_RESERVE = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_RESERVED = 2'd0,
		ST_NO_ROOM  = 2'd1,
		ST_RELEASED = 2'd2,
		ST_INVALID  = 2'd3
	} status_t;

	// control handed to every cell for the request in flight
	typedef struct packed {
		logic             upd;
		logic             reserve;
		logic             rel;
		logic [CntW-1:0]  count;
	} cell_ctl_t;

	// mask of n low ones
	function automatic slot_vec_t run_mask(input logic [CntW-1:0] n);
		slot_vec_t m;
		for (int i = 0; i < NumSlots; i++) begin
			m[i] = (CntW'(i) < n);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/csa_req_if.sv =====
// ---------------------------------------------------------------------------
// csa_req_if
// request channel: action, count and first slot with valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface csa_req_if;
	import csa_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [CntW-1:0]     count;
	logic [SlotW-1:0]    first_slot;

	modport source (output valid, output action, output count, output first_slot,
		input ready);
	modport sink (input valid, input action, input count, input first_slot,
		output ready);
endinterface

`default_nettype wire

// ===== design/csa_rsp_if.sv =====
// ---------------------------------------------------------------------------
// csa_rsp_if
// result channel: status and granted start with valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface csa_rsp_if;
	import csa_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [SlotW-1:0]    granted_start;

	modport source (output valid, output status, output granted_start, input ready);
	modport sink (input valid, input status, input granted_start, output ready);
endinterface

`default_nettype wire

// ===== design/csa_cell.sv =====
// ---------------------------------------------------------------------------
// csa_cell
// one slot of the chain: occupancy bit, fit test and first-fit hand-off
// ---------------------------------------------------------------------------
`default_nettype none

module csa_cell
	import csa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctl_t  ctl,
	input  wire slot_vec_t  win,
	input  wire slot_vec_t  gwin,
	input  wire logic       rel_hit,
	input  wire logic       found_in,
	output logic            occ,
	output logic            grant,
	output logic            found_out
);

	logic      occ_q;
	logic      fit;
	logic      set_hit;
	slot_vec_t mask;

	// a run of count free slots starts here when the window is clear
	always_comb begin
		mask      = run_mask(ctl.count);
		fit       = ctl.reserve && ((win & mask) == '0);
		grant     = fit && !found_in;
		found_out = found_in || fit;
		set_hit   = |(gwin & mask);
	end

	// occupancy update when the request completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.upd) begin
			if (ctl.reserve && set_hit) begin
				occ_q <= 1'b1;
			end else if (ctl.rel && rel_hit) begin
				occ_q <= 1'b0;
			end
		end
	end

	assign occ = occ_q;

endmodule

`default_nettype wire

// ===== design/contiguous_slot_allocator_core.sv =====
// result path: request captured in the holding register, result captured in the output register
// a new request is taken only once the held one is processed; a result not taken stalls intake
// the first-fit search and map update settle in one pass along the cell chain
// reset: all slots free, no request held, no result pending
// ---------------------------------------------------------------------------
// contiguous_slot_allocator_core
// first-fit allocator of contiguous slot runs over a chain of slot cells
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module contiguous_slot_allocator_core
	import csa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	csa_req_if.sink    req,
	csa_rsp_if.source  rsp
);

	localparam int SumW = CntW + 1;

	logic              busy_q;
	logic              act_s1;
	logic [CntW-1:0]   count_s1;
	logic [SlotW-1:0]  first_s1;

	logic              out_valid_q;
	status_t           status_q;
	logic [SlotW-1:0]  start_q;

	logic              proc;
	logic              cnt_ok;
	logic              end_ok;
	cell_ctl_t         ctl;
	slot_vec_t         occ_map;
	slot_vec_t         grant_vec;
	slot_vec_t         rel_mask;
	slot_vec_t         win   [NumSlots];
	slot_vec_t         gwin  [NumSlots];
	logic [NumSlots:0] found;
	status_t           res_status;
	logic [SlotW-1:0]  res_start;

	// request holding register
	assign req.ready = !busy_q;
	assign proc      = busy_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (proc) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_s1   <= req.action;
			count_s1 <= req.count;
			first_s1 <= req.first_slot;
		end
	end

	// request checks and cell control
	always_comb begin
		cnt_ok      = (count_s1 != '0) && (count_s1 <= CntW'(NumSlots));
		end_ok      = (SumW'(first_s1) + SumW'(count_s1)) <= SumW'(NumSlots);
		ctl.upd     = proc;
		ctl.reserve = busy_q && (act_s1 == ACT_RESERVE) && cnt_ok;
		ctl.rel     = busy_q && (act_s1 == ACT_RELEASE) && cnt_ok && end_ok;
		ctl.count   = count_s1;
		rel_mask    = run_mask(count_s1) << first_s1;
	end

	// neighbour windows: occupancy upward, padded busy past the end;
	// grants downward, padded clear below slot zero
	for (genvar i = 0; i < NumSlots; i++) begin : g_win
		for (genvar k = 0; k < NumSlots; k++) begin : g_bit
			if (i + k < NumSlots) begin : g_in
				assign win[i][k] = occ_map[i+k];
			end else begin : g_pad
				assign win[i][k] = 1'b1;
			end
			if (i - k >= 0) begin : g_gin
				assign gwin[i][k] = grant_vec[i-k];
			end else begin : g_gpad
				assign gwin[i][k] = 1'b0;
			end
		end
	end

	// chain of slot cells, first-fit flag passed upward
	assign found[0] = 1'b0;

	for (genvar i = 0; i < NumSlots; i++) begin : g_cell
		csa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.win       (win[i]),
			.gwin      (gwin[i]),
			.rel_hit   (rel_mask[i]),
			.found_in  (found[i]),
			.occ       (occ_map[i]),
			.grant     (grant_vec[i]),
			.found_out (found[i+1])
		);
	end

	// result encoding
	always_comb begin
		res_start = '0;
		for (int i = 0; i < NumSlots; i++) begin
			if (grant_vec[i]) begin
				res_start = res_start | SlotW'(i);
			end
		end
		if (!cnt_ok) begin
			res_status = ST_INVALID;
		end else if (act_s1 == ACT_RESERVE) begin
			res_status = found[NumSlots] ? ST_RESERVED : ST_NO_ROOM;
		end else begin
			res_status = end_ok ? ST_RELEASED : ST_INVALID;
		end
		if (res_status != ST_RESERVED) begin
			res_start = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			status_q <= res_status;
			start_q  <= res_start;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_start = start_q;

	// checks
	`CSA_ASSERT_ALWAYS(a_one_grant, $onehot0(grant_vec), "more than one cell granted")
	`CSA_ASSERT(a_grant_marked, proc && res_status == ST_RESERVED |=> occ_map[start_q], "granted start not occupied")
	`CSA_ASSERT(a_no_room_keeps_map, proc && res_status == ST_NO_ROOM |=> occ_map == $past(occ_map), "map changed on no room")
	`CSA_ASSERT(a_start_zero, out_valid_q && status_q != ST_RESERVED |-> start_q == '0, "start not zero without grant")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the contiguous slot allocator against a first-fit occupancy map kept
// in the bench. Each accepted request is predicted in order and every result
// is compared field by field. Directed corner requests come first. Random
// traffic follows under several idling mixes, with a long result hold-off.
// ---------------------------------------------------------------------------

module testbench;
	import csa_pkg::*;

	// predicted answer of one request
	typedef struct {
		status_t          status;
		logic [SlotW-1:0] start;
	} alloc_result_t;

	// a run handed out by the block and not yet given back
	typedef struct {
		logic [SlotW-1:0] start;
		logic [CntW-1:0]  len;
	} slot_run_t;

	logic clk;
	logic arst_n;

	csa_req_if req_if ();
	csa_rsp_if rsp_if ();

	contiguous_slot_allocator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	slot_vec_t     occupancy;
	alloc_result_t pending_results[$];
	slot_run_t     held_runs[$];
	int            mismatches     = 0;
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	int            hold_left      = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// first-fit prediction, updates the bench copy of the map
	function automatic alloc_result_t predict_allocation(input action_t act,
		input logic [CntW-1:0] cnt, input logic [SlotW-1:0] first);
		alloc_result_t res;
		slot_vec_t     run;
		bit            found;
		res.status = ST_INVALID;
		res.start  = '0;
		found      = 1'b0;
		run        = '0;
		for (int i = 0; i < NumSlots; i++) begin
			run[i] = (i < int'(cnt));
		end
		if (cnt == 0 || int'(cnt) > NumSlots) begin
			res.status = ST_INVALID;
		end else if (act == ACT_RESERVE) begin
			for (int s = 0; s + int'(cnt) <= NumSlots && !found; s++) begin
				if (((occupancy >> s) & run) == '0) begin
					found     = 1'b1;
					res.start = SlotW'(s);
				end
			end
			if (found) begin
				occupancy  = occupancy | (run << res.start);
				res.status = ST_RESERVED;
			end else begin
				res.status = ST_NO_ROOM;
			end
		end else if (int'(first) + int'(cnt) > NumSlots) begin
			res.status = ST_INVALID;
		end else begin
			occupancy  = occupancy & ~(run << first);
			res.status = ST_RELEASED;
		end
		return res;
	endfunction

	// offer one request, wait for the handshake and record the prediction
	task automatic send_request(input action_t act, input logic [CntW-1:0] cnt,
		input logic [SlotW-1:0] first);
		alloc_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.action     <= act;
		req_if.count      <= cnt;
		req_if.first_slot <= first;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		res = predict_allocation(act, cnt, first);
		pending_results.push_back(res);
		if (res.status == ST_RESERVED) begin
			held_runs.push_back('{res.start, cnt});
		end
	endtask

	// sender goes quiet until every result is back
	task automatic wait_until_drained();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// corner requests from an empty map
	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(ACT_RESERVE, 5'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd17, 4'd0);
		send_request(ACT_RESERVE, 5'd31, 4'd15);
		send_request(ACT_RELEASE, 5'd0, 4'd0);
		send_request(ACT_RESERVE, 5'd16, 4'd15);
		send_request(ACT_RESERVE, 5'd1, 4'd0);
		send_request(ACT_RELEASE, 5'd16, 4'd0);
		send_request(ACT_RESERVE, 5'd1, 4'd0);
		send_request(ACT_RESERVE, 5'd3, 4'd0);
		send_request(ACT_RESERVE, 5'd4, 4'd0);
		send_request(ACT_RESERVE, 5'd8, 4'd0);
		send_request(ACT_RELEASE, 5'd3, 4'd1);
		send_request(ACT_RESERVE, 5'd4, 4'd0);
		send_request(ACT_RESERVE, 5'd2, 4'd9);
		send_request(ACT_RELEASE, 5'd2, 4'd15);
		send_request(ACT_RELEASE, 5'd1, 4'd15);
		// releasing a slot that is already free, an invalid count, then the whole map
		send_request(ACT_RELEASE, 5'd1, 4'd15);
		send_request(ACT_RELEASE, 5'd31, 4'd0);
		send_request(ACT_RELEASE, 5'd16, 4'd0);
		send_request(ACT_RESERVE, 5'd15, 4'd10);
		send_request(ACT_RESERVE, 5'd1, 4'd5);
		send_request(ACT_RESERVE, 5'd1, 4'd0);
		send_request(ACT_RELEASE, 5'd16, 4'd0);
		wait_until_drained();
		held_runs.delete();
	endtask

	// one random request: mostly reserves and releases of held runs
	task automatic send_random_request();
		int        pick;
		int        idx;
		slot_run_t run;
		pick = $urandom_range(99);
		if (pick < 55) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				send_request(ACT_RESERVE, CntW'($urandom_range(1, 4)),
					SlotW'($urandom_range(0, 15)));
			end else if (pick < 85) begin
				send_request(ACT_RESERVE, CntW'($urandom_range(5, 8)),
					SlotW'($urandom_range(0, 15)));
			end else if (pick < 95) begin
				send_request(ACT_RESERVE, CntW'($urandom_range(9, 16)),
					SlotW'($urandom_range(0, 15)));
			end else begin
				send_request(ACT_RESERVE, CntW'($urandom_range(0, 31)),
					SlotW'($urandom_range(0, 15)));
			end
		end else if (held_runs.size() != 0 && $urandom_range(99) < 75) begin
			idx = $urandom_range(held_runs.size() - 1);
			run = held_runs[idx];
			held_runs.delete(idx);
			send_request(ACT_RELEASE, run.len, run.start);
		end else if ($urandom_range(1) == 0) begin
			send_request(ACT_RELEASE, CntW'($urandom_range(1, 8)),
				SlotW'($urandom_range(0, 15)));
		end else begin
			send_request(ACT_RELEASE, CntW'($urandom_range(0, 31)),
				SlotW'($urandom_range(0, 15)));
		end
	endtask

	// random traffic under one idling mix
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
		input int n_req);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n_req) send_random_request();
		wait_until_drained();
	endtask

	// results held back for a long stretch while requests keep coming
	task automatic test_result_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 150;
		repeat (24) send_random_request();
		wait_until_drained();
	endtask

	// result ready, with random stalls and the long hold-off
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left    = hold_left - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request waiting, expected none, got status %0d start %0d",
					$time, rsp_if.status, rsp_if.granted_start);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.status !== want.status) begin
					mismatches++;
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, rsp_if.status);
				end
				if (rsp_if.granted_start !== want.start) begin
					mismatches++;
					$display("%0t: granted_start mismatch, expected %0d, got %0d",
						$time, want.start, rsp_if.granted_start);
				end
			end
		end
	end

	// sequence of tests
	initial begin
		arst_n            <= 1'b0;
		req_if.valid      <= 1'b0;
		req_if.action     <= ACT_RESERVE;
		req_if.count      <= '0;
		req_if.first_slot <= '0;
		occupancy          = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_traffic(0, 0, 100);
		test_result_backpressure();
		test_random_traffic(57, 0, 100);
		test_random_traffic(0, 57, 100);
		test_random_traffic(27, 27, 100);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== contiguous_slot_allocator_core.f =====
+incdir+design
design/csa_pkg.sv
design/csa_req_if.sv
design/csa_rsp_if.sv
design/csa_cell.sv
design/contiguous_slot_allocator_core.sv
dv/testbench.sv
